// File: rtl/core/uvs_pkg.sv
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared types, constants and arithmetic helpers of the UV sphere vertex
// generator.
// ----------------------------------------------------------------------------
package uvs_pkg;

    // Width of the CORDIC datapath (Q2.30 plus guard bits).
    localparam int CW = 34;
    // Width of the reciprocal used for the angle scaling (ceil(2^48 / d)).
    localparam int RW = 49;
    localparam int ATAN_ENTRIES = 24;

    localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;

    localparam logic [31:0] ATAN_TAB [0:ATAN_ENTRIES-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // Register indexes of the configuration channel.
    localparam logic [1:0] REG_RADIUS  = 2'd0;
    localparam logic [1:0] REG_RINGS   = 2'd1;
    localparam logic [1:0] REG_SECTORS = 2'd2;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } cord_t;

    // Six wrapped vertex indices of the quad's two triangles.
    typedef logic [5:0][14:0] tri_t;

    // One micro-rotation of the CORDIC rotator.
    function automatic cord_t cordic_step(cord_t c, int unsigned i);
        cord_t                n;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        logic signed [CW-1:0] at;
        begin
            dx = c.y >>> i;
            dy = c.x >>> i;
            at = $signed({2'b00, ATAN_TAB[i]});
            if (!c.z[CW-1])
            begin
                n.x = c.x - dx;
                n.y = c.y + dy;
                n.z = c.z - at;
            end
            else
            begin
                n.x = c.x + dx;
                n.y = c.y - dy;
                n.z = c.z + at;
            end
            return n;
        end
    endfunction

    // Q2.30 to Q1.14, rounded half up and clamped to +-1.0.
    function automatic logic signed [15:0] round_trig(logic signed [CW-1:0] v);
        logic signed [CW:0] t;
        begin
            t = ($signed({v[CW-1], v}) + 35'sd32768) >>> 16;
            if (t > 35'sd16384)
                return 16'sd16384;
            else if (t < -35'sd16384)
                return -16'sd16384;
            else
                return t[15:0];
        end
    endfunction

    // Q2.28 product to Q1.14, rounded half up and clamped to +-1.0.
    function automatic logic signed [15:0] round_q14(logic signed [31:0] v);
        logic signed [31:0] t;
        begin
            t = (v + 32'sd8192) >>> 14;
            if (t > 32'sd16384)
                return 16'sd16384;
            else if (t < -32'sd16384)
                return -16'sd16384;
            else
                return t[15:0];
        end
    endfunction

endpackage

// File: rtl/core/uv_sphere_vertex_generator.sv
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator
// Turns one grid point of a UV sphere into its vertex, unit normal and the
// two triangles of the quad that starts at that point.
// ----------------------------------------------------------------------------
// Usage: each transaction on the slave stream carries one grid point (ring
// and sector index). Each transaction on the master stream carries the
// Q8.8 vertex position, the Q1.14 unit normal and six wrapped vertex
// indices. Indices past the configured counts are clamped to the last ring
// or sector. The configuration channel writes radius, ring count and
// sector count; it is always ready.
// Throughput is one grid point per clock while no reciprocal is being
// formed and the receiver does not stall. An input passes through
// TRIG_STAGES + 9 register stages to the output register; the two CORDIC
// rotators, one register stage per micro-rotation, make up most of them.
// The angle scaling multiplies by reciprocals of (rings - 1) and
// (sectors - 1). A serial divider, one quotient bit per cycle in which no
// configuration write arrives, forms them after reset and after every
// write of a ring or sector count; s_tready stays low until it is done.
// When the receiver stalls, the whole pipeline holds its contents and
// s_tready drops; nothing is lost or repeated. At reset the registers
// take radius 1.0, 16 rings and 16 sectors, and the pipeline empties.
module uv_sphere_vertex_generator #(
    parameter int MAX_RINGS   = 256,
    parameter int MAX_SECTORS = 128,
    parameter int TRIG_STAGES = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    // Configuration write channel.
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    // Slave stream.
    input  logic         s_tvalid,
    output logic         s_tready,
    // ring_index[7:0], sector_index[14:8], zero pad[15]
    input  logic [15:0]  s_tdata,
    // Master stream.
    output logic         m_tvalid,
    input  logic         m_tready,
    // pos_x[16:0], pos_y[33:17], pos_z[50:34], nrm_x[66:51], nrm_y[82:67],
    // nrm_z[98:83], first_tri_a[113:99], first_tri_b[128:114],
    // first_tri_c[143:129], second_tri_a[158:144], second_tri_b[173:159],
    // second_tri_c[188:174], zero pad[191:189]
    output logic [191:0] m_tdata
);
    import uvs_pkg::*;

    // ---------------- configuration registers and reciprocals ------------
    logic [15:0]   radius_reg;
    logic [8:0]    ring_count_reg;
    logic [7:0]    sector_count_reg;
    logic          busy_reg;
    logic [5:0]    step_reg;
    logic [7:0]    rem_p_reg, rem_a_reg;
    logic [47:0]   q_p_reg, q_a_reg;
    logic [RW-1:0] m_p_reg, m_a_reg;
    logic [16:0]   count_reg;

    logic [8:0]    rings_eff;
    logic [7:0]    sectors_eff;
    logic [7:0]    d_pol;
    logic [6:0]    d_az;
    logic [8:0]    rp2, ra2;
    logic          ge_p, ge_a;
    logic [7:0]    rem_p_next, rem_a_next;
    logic [47:0]   q_p_next, q_a_next;

    always_comb
    begin
        if (ring_count_reg < 9'd2)
            rings_eff = 9'd2;
        else if (ring_count_reg > 9'(MAX_RINGS))
            rings_eff = 9'(MAX_RINGS);
        else
            rings_eff = ring_count_reg;
        if (sector_count_reg < 8'd2)
            sectors_eff = 8'd2;
        else if (sector_count_reg > 8'(MAX_SECTORS))
            sectors_eff = 8'(MAX_SECTORS);
        else
            sectors_eff = sector_count_reg;
    end

    assign d_pol = 8'(rings_eff - 9'd1);
    assign d_az  = 7'(sectors_eff - 8'd1);

    // Restoring division of 2^48 - 1: every dividend bit shifted in is one.
    assign rp2        = {rem_p_reg, 1'b1};
    assign ra2        = {rem_a_reg, 1'b1};
    assign ge_p       = rp2 >= {1'b0, d_pol};
    assign ge_a       = ra2 >= {2'b00, d_az};
    assign rem_p_next = ge_p ? 8'(rp2 - {1'b0, d_pol}) : rp2[7:0];
    assign rem_a_next = ge_a ? 8'(ra2 - {2'b00, d_az}) : ra2[7:0];
    assign q_p_next   = {q_p_reg[46:0], ge_p};
    assign q_a_next   = {q_a_reg[46:0], ge_a};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg       <= 16'd256;
            ring_count_reg   <= 9'd16;
            sector_count_reg <= 8'd16;
            busy_reg         <= 1'b1;
            step_reg         <= '0;
            rem_p_reg        <= '0;
            rem_a_reg        <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_RADIUS:  radius_reg <= cfg_data;
                REG_RINGS:   ring_count_reg <= cfg_data[8:0];
                REG_SECTORS: sector_count_reg <= cfg_data[7:0];
                default:     ;
            endcase
            if (cfg_index == REG_RINGS || cfg_index == REG_SECTORS)
            begin
                busy_reg  <= 1'b1;
                step_reg  <= '0;
                rem_p_reg <= '0;
                rem_a_reg <= '0;
            end
        end
        else if (busy_reg)
        begin
            rem_p_reg <= rem_p_next;
            rem_a_reg <= rem_a_next;
            step_reg  <= step_reg + 6'd1;
            if (step_reg == 6'd47)
                busy_reg <= 1'b0;
        end
    end

    // The quotient moves only in the cycles in which the remainder moves.
    always_ff @(posedge clk)
    begin
        if (busy_reg && !cfg_valid)
        begin
            q_p_reg <= q_p_next;
            q_a_reg <= q_a_next;
            if (step_reg == 6'd47)
            begin
                m_p_reg   <= {1'b0, q_p_next} + RW'(1);
                m_a_reg   <= {1'b0, q_a_next} + RW'(1);
                count_reg <= 17'(rings_eff * sectors_eff);
            end
        end
    end

    assign cfg_ready = 1'b1;

    // ---------------- pipeline control ------------------------------------
    // One enable for all stages: everything moves unless the output holds
    // a result that the receiver does not take.
    logic en;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg, v9_reg;
    logic cv_reg [1:TRIG_STAGES];

    assign en       = !v9_reg || m_tready;
    assign s_tready = en && !busy_reg;
    assign m_tvalid = v9_reg;

    // Stage 1: clamp the grid point.
    logic [7:0] rc_reg;
    logic [6:0] sc_reg;

    // Stage 2: partial products of the angle scaling and the row start.
    logic [32:0] pp_pl_reg, pp_al_reg;
    logic [31:0] pp_ph_reg;
    logic [30:0] pp_ah_reg;
    logic [15:0] cur_reg;
    logic [6:0]  sc2_reg;

    // Stage 3: phases and wrapped indices.
    logic [31:0] ph_p_reg, ph_a_reg;
    tri_t        tri3_reg;
    logic [56:0] sum_p, sum_a;
    logic [16:0] v_idx [0:3];
    logic [14:0] w_idx [0:3];

    // Stage 4: CORDIC start values.
    cord_t       c4_p_reg, c4_a_reg;
    logic [1:0]  fl4_reg;
    tri_t        tri4_reg;
    logic [31:0] pp, pa;
    logic        flp, fla;

    cord_t cp_reg [1:TRIG_STAGES];
    cord_t ca_reg [1:TRIG_STAGES];
    logic [1:0] fl_reg [1:TRIG_STAGES];
    tri_t tri_c_reg [1:TRIG_STAGES];

    logic signed [15:0] cos_p_reg, sin_p_reg, cos_a_reg, sin_a_reg;
    tri_t tri5_reg, tri6_reg, tri7_reg, tri8_reg;
    logic signed [31:0] prx_reg, prz_reg;
    logic signed [15:0] cp6_reg;
    logic signed [15:0] nx_reg, ny_reg, nz_reg, nx8_reg, ny8_reg, nz8_reg;
    logic signed [32:0] px_reg, py_reg, pz_reg;
    logic signed [32:0] rad_s;
    logic signed [32:0] rx, ry, rz;

    always_comb
    begin
        sum_p = {pp_ph_reg, 25'd0} + 57'(pp_pl_reg);
        sum_a = {1'b0, pp_ah_reg, 25'd0} + 57'(pp_al_reg);
        v_idx[0] = 17'(cur_reg) + 17'(sc2_reg);
        v_idx[1] = 17'(cur_reg) + 17'(sectors_eff) + 17'(sc2_reg);
        v_idx[2] = v_idx[1] + 17'd1;
        v_idx[3] = v_idx[0] + 17'd1;
        for (int k = 0; k < 4; k++)
        begin
            if (v_idx[k] >= count_reg)
                w_idx[k] = 15'(v_idx[k] - count_reg);
            else
                w_idx[k] = v_idx[k][14:0];
        end
        // A phase in the left half-plane is turned by half a turn.
        flp = ph_p_reg[31] ^ ph_p_reg[30];
        fla = ph_a_reg[31] ^ ph_a_reg[30];
        pp  = flp ? (ph_p_reg ^ 32'h8000_0000) : ph_p_reg;
        pa  = fla ? (ph_a_reg ^ 32'h8000_0000) : ph_a_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
            v9_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_tvalid && s_tready;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= cv_reg[TRIG_STAGES];
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
            v9_reg <= v8_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Stage 1
            rc_reg <= (s_tdata[7:0] > d_pol) ? d_pol : s_tdata[7:0];
            sc_reg <= (s_tdata[14:8] > d_az) ? d_az : s_tdata[14:8];
            // Stage 2
            pp_pl_reg <= 33'(rc_reg) * 33'(m_p_reg[24:0]);
            pp_ph_reg <= 32'(rc_reg) * 32'(m_p_reg[48:25]);
            pp_al_reg <= 33'(sc_reg) * 33'(m_a_reg[24:0]);
            pp_ah_reg <= 31'(sc_reg) * 31'(m_a_reg[48:25]);
            cur_reg   <= 16'(rc_reg * sectors_eff);
            sc2_reg   <= sc_reg;
            // Stage 3: r * 2^31 / d and s * 2^32 / d, the latter mod 2^32.
            ph_p_reg <= sum_p[48:17];
            ph_a_reg <= sum_a[47:16];
            tri3_reg <= {w_idx[3], w_idx[2], w_idx[0], w_idx[2], w_idx[1], w_idx[0]};
            // Stage 4
            c4_p_reg <= '{x: CORDIC_X0, y: '0, z: CW'($signed(pp))};
            c4_a_reg <= '{x: CORDIC_X0, y: '0, z: CW'($signed(pa))};
            fl4_reg  <= {fla, flp};
            tri4_reg <= tri3_reg;
            // Stage 5: undo the half turn, round to Q1.14.
            cos_p_reg <= round_trig(fl_reg[TRIG_STAGES][0] ? -cp_reg[TRIG_STAGES].x
                                                           : cp_reg[TRIG_STAGES].x);
            sin_p_reg <= round_trig(fl_reg[TRIG_STAGES][0] ? -cp_reg[TRIG_STAGES].y
                                                           : cp_reg[TRIG_STAGES].y);
            cos_a_reg <= round_trig(fl_reg[TRIG_STAGES][1] ? -ca_reg[TRIG_STAGES].x
                                                           : ca_reg[TRIG_STAGES].x);
            sin_a_reg <= round_trig(fl_reg[TRIG_STAGES][1] ? -ca_reg[TRIG_STAGES].y
                                                           : ca_reg[TRIG_STAGES].y);
            tri5_reg  <= tri_c_reg[TRIG_STAGES];
            // Stage 6
            prx_reg  <= 32'(cos_a_reg) * 32'(sin_p_reg);
            prz_reg  <= 32'(sin_a_reg) * 32'(sin_p_reg);
            cp6_reg  <= cos_p_reg;
            tri6_reg <= tri5_reg;
            // Stage 7
            nx_reg   <= round_q14(prx_reg);
            ny_reg   <= -cp6_reg;
            nz_reg   <= round_q14(prz_reg);
            tri7_reg <= tri6_reg;
            // Stage 8
            px_reg   <= 33'(nx_reg) * rad_s;
            py_reg   <= 33'(ny_reg) * rad_s;
            pz_reg   <= 33'(nz_reg) * rad_s;
            nx8_reg  <= nx_reg;
            ny8_reg  <= ny_reg;
            nz8_reg  <= nz_reg;
            tri8_reg <= tri7_reg;
            // Stage 9: output register.
            m_tdata <= {3'b000, tri8_reg, nz8_reg, ny8_reg, nx8_reg,
                        rz[16:0], ry[16:0], rx[16:0]};
        end
    end

    assign rad_s = 33'($signed({1'b0, radius_reg}));
    assign rx    = (px_reg + 33'sd8192) >>> 14;
    assign ry    = (py_reg + 33'sd8192) >>> 14;
    assign rz    = (pz_reg + 33'sd8192) >>> 14;

    // ---------------- CORDIC rotators: one micro-rotation per stage --------
    for (genvar i = 1; i <= TRIG_STAGES; i++)
    begin : g_cordic
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                cv_reg[i] <= 1'b0;
            else if (en)
                cv_reg[i] <= (i == 1) ? v4_reg : cv_reg[(i == 1) ? 1 : i - 1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (i == 1)
                begin
                    cp_reg[i]    <= cordic_step(c4_p_reg, 0);
                    ca_reg[i]    <= cordic_step(c4_a_reg, 0);
                    fl_reg[i]    <= fl4_reg;
                    tri_c_reg[i] <= tri4_reg;
                end
                else
                begin
                    cp_reg[i]    <= cordic_step(cp_reg[(i == 1) ? 1 : i - 1], i - 1);
                    ca_reg[i]    <= cordic_step(ca_reg[(i == 1) ? 1 : i - 1], i - 1);
                    fl_reg[i]    <= fl_reg[(i == 1) ? 1 : i - 1];
                    tri_c_reg[i] <= tri_c_reg[(i == 1) ? 1 : i - 1];
                end
            end
        end
    end

endmodule

// File: verif/uv_sphere_vertex_generator_tb.sv
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator_tb
// Self-checking testbench for the UV sphere vertex generator. Grid points are
// streamed in under several radius, ring and sector settings and with random
// idle cycles on both streams. Every output transaction is checked field by
// field against a vertex predictor kept inside the testbench.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import uvs_pkg::*;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = REG_RADIUS;
    logic [15:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [15:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [191:0] m_tdata;

    // Register index that no register answers to; writes to it are dropped.
    localparam logic [1:0] REG_UNUSED = 2'd3;

    // Output fields from the lowest bit up.
    localparam int    FIELD_W [12] = '{17, 17, 17, 16, 16, 16, 15, 15, 15, 15, 15, 15};
    localparam string FIELD_N [12] = '{"pos_x", "pos_y", "pos_z", "nrm_x", "nrm_y",
        "nrm_z", "first_tri_a", "first_tri_b", "first_tri_c", "second_tri_a",
        "second_tri_b", "second_tri_c"};

    // Pipeline latency plus margin, used for the pause before a register write
    // and at the end of the run.
    localparam int DRAIN_CYCLES = 40;

    // Testbench copy of the configuration registers.
    int unsigned sphere_radius = 256;
    int unsigned sphere_rings = 16;
    int unsigned sphere_sectors = 16;

    // Percentage of cycles in which the sender idles or the receiver stalls.
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    logic [15:0]  grid_points_pending[$];
    logic [191:0] vertices_expected[$];
    int unsigned  mismatch_count = 0;
    int unsigned  orphan_count = 0;

    uv_sphere_vertex_generator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Appends one grid point to the end of the pending queue.
    function automatic void enqueue_point(input logic [15:0] point);
        grid_points_pending.insert(grid_points_pending.size(), point);
    endfunction

    // ------------------------------------------------------------------------
    // Vertex predictor
    // ------------------------------------------------------------------------

    function automatic longint clamp_unit(longint v);
        if (v > 16384)
            return 16384;
        if (v < -16384)
            return -16384;
        return v;
    endfunction

    // Cosine and sine of a 32-bit phase (a full turn is 2^32) in Q1.14. Phases
    // in the left half-plane are rotated by half a turn and the result negated.
    function automatic void phase_to_trig(input logic [31:0] phase, output longint cosv,
                                          output longint sinv);
        logic [31:0] turned;
        logic        flip;
        longint      x;
        longint      y;
        longint      z;
        longint      dx;
        longint      dy;
        flip   = phase[31] ^ phase[30];
        turned = flip ? phase - 32'h8000_0000 : phase;
        z      = longint'($signed(turned));
        x      = longint'(CORDIC_X0);
        y      = 0;
        for (int i = 0; i < 16; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(ATAN_TAB[i]);
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(ATAN_TAB[i]);
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        cosv = clamp_unit((x + 32768) >>> 16);
        sinv = clamp_unit((y + 32768) >>> 16);
    endfunction

    // Indices at or past the vertex count fold back once.
    function automatic logic [14:0] fold_index(int unsigned v, int unsigned count);
        return (v >= count) ? 15'(v - count) : 15'(v);
    endfunction

    function automatic logic [191:0] vertex_of(logic [15:0] point);
        int unsigned       rings;
        int unsigned       sectors;
        int unsigned       r;
        int unsigned       s;
        int unsigned       count;
        int unsigned       cur;
        int unsigned       nxt;
        longint unsigned   pol_ph;
        longint unsigned   az_ph;
        longint            cp;
        longint            sp;
        longint            ca;
        longint            sa;
        longint            nx;
        longint            ny;
        longint            nz;
        logic [191:0]      v;
        rings   = sphere_rings;
        sectors = sphere_sectors;
        if (rings < 2)
            rings = 2;
        if (rings > 256)
            rings = 256;
        if (sectors < 2)
            sectors = 2;
        if (sectors > 128)
            sectors = 128;
        r = point[7:0];
        s = point[14:8];
        if (r > rings - 1)
            r = rings - 1;
        if (s > sectors - 1)
            s = sectors - 1;

        pol_ph = (longint'(r) << 31) / (rings - 1);
        az_ph  = (longint'(s) << 32) / (sectors - 1);
        phase_to_trig(pol_ph[31:0], cp, sp);
        phase_to_trig(az_ph[31:0], ca, sa);
        nx = clamp_unit((ca * sp + 8192) >>> 14);
        ny = -cp;
        nz = clamp_unit((sa * sp + 8192) >>> 14);

        count = rings * sectors;
        cur   = r * sectors;
        nxt   = cur + sectors;

        v          = '0;
        v[16:0]    = 17'((nx * longint'(sphere_radius) + 8192) >>> 14);
        v[33:17]   = 17'((ny * longint'(sphere_radius) + 8192) >>> 14);
        v[50:34]   = 17'((nz * longint'(sphere_radius) + 8192) >>> 14);
        v[66:51]   = 16'(nx);
        v[82:67]   = 16'(ny);
        v[98:83]   = 16'(nz);
        v[113:99]  = fold_index(cur + s, count);
        v[128:114] = fold_index(nxt + s, count);
        v[143:129] = fold_index(nxt + s + 1, count);
        v[158:144] = fold_index(cur + s, count);
        v[173:159] = fold_index(nxt + s + 1, count);
        v[188:174] = fold_index(cur + s + 1, count);
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: presents queued grid points with random idle cycles. A new
    // point is loaded only when the current one has been taken or none is
    // shown, so s_tdata is stable while s_tvalid waits for s_tready. The
    // expected vertex is predicted at the edge that accepts the point.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                vertices_expected.insert(vertices_expected.size(), vertex_of(s_tdata));
            if (!s_tvalid || s_tready)
            begin
                if (grid_points_pending.size() != 0 &&
                    $urandom_range(99) >= send_idle_pct)
                begin
                    s_tdata  <= grid_points_pending.pop_front();
                    s_tvalid <= 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: random back-pressure, and every accepted output transaction is
    // compared field by field against the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        logic [191:0] want;
        int           lo;
        logic [16:0]  got_f;
        logic [16:0]  want_f;
        logic [16:0]  mask_f;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
            if (m_tvalid && m_tready)
            begin
                if (vertices_expected.size() == 0)
                begin
                    orphan_count++;
                    if (mismatch_count + orphan_count <= 10)
                        $display("ERROR: unexpected output transaction %h", m_tdata);
                end
                else
                begin
                    want = vertices_expected.pop_front();
                    lo   = 0;
                    for (int f = 0; f < 12; f++)
                    begin
                        mask_f = 17'((64'd1 << FIELD_W[f]) - 64'd1);
                        got_f  = 17'(m_tdata >> lo) & mask_f;
                        want_f = 17'(want >> lo) & mask_f;
                        if (got_f !== want_f)
                        begin
                            mismatch_count++;
                            if (mismatch_count + orphan_count <= 10)
                                $display("ERROR: %s expected %h got %h", FIELD_N[f],
                                         want_f, got_f);
                        end
                        lo += FIELD_W[f];
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequencing
    // ------------------------------------------------------------------------

    // Register writes happen only with the pipeline empty; the testbench copy
    // of the register is updated at the accepting edge.
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_RADIUS:  sphere_radius = value;
            REG_RINGS:   sphere_rings = value[8:0];
            REG_SECTORS: sphere_sectors = value[7:0];
            default:     ;
        endcase
    endtask

    task automatic wait_idle();
        while (grid_points_pending.size() != 0 || s_tvalid ||
               vertices_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Random grid points: most inside the configured grid, the rest anywhere
    // in the field range so that clamping gets exercised too.
    task automatic queue_random_points(input int n);
        int unsigned rmax;
        int unsigned smax;
        rmax = (sphere_rings < 2) ? 1 : (sphere_rings > 256 ? 255 : sphere_rings - 1);
        smax = (sphere_sectors < 2) ? 1 : (sphere_sectors > 128 ? 127 : sphere_sectors - 1);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(9) < 8)
                enqueue_point({1'b0, 7'($urandom_range(smax)),
                               8'($urandom_range(rmax))});
            else
                enqueue_point({1'b0, 7'($urandom), 8'($urandom)});
        end
    endtask

    task automatic set_pressure(input int unsigned phase);
        case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
            default: begin send_idle_pct = 22; recv_stall_pct = 22; end
        endcase
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed points under the reset configuration: poles, the seam,
        // the last ring and sector, and indices past the grid that clamp.
        enqueue_point({1'b0, 7'd0,   8'd0});
        enqueue_point({1'b0, 7'd15,  8'd15});
        enqueue_point({1'b0, 7'd0,   8'd15});
        enqueue_point({1'b0, 7'd15,  8'd0});
        enqueue_point({1'b0, 7'd127, 8'd255});
        enqueue_point({1'b0, 7'd4,   8'd7});
        enqueue_point({1'b0, 7'd8,   8'd8});
        enqueue_point({1'b0, 7'd12,  8'd3});
        enqueue_point({1'b0, 7'd100, 8'd2});
        enqueue_point({1'b0, 7'd3,   8'd200});
        wait_idle();

        // Extreme settings, each with a handful of directed points.
        // Largest radius, smallest grid.
        write_reg(REG_RADIUS, 16'hFFFF);
        write_reg(REG_RINGS, 16'd2);
        write_reg(REG_SECTORS, 16'd2);
        enqueue_point({1'b0, 7'd0,   8'd0});
        enqueue_point({1'b0, 7'd1,   8'd1});
        enqueue_point({1'b0, 7'd127, 8'd255});
        wait_idle();

        // Zero radius, largest grid: indices reach the top of their range.
        write_reg(REG_RADIUS, 16'd0);
        write_reg(REG_RINGS, 16'd256);
        write_reg(REG_SECTORS, 16'd128);
        enqueue_point({1'b0, 7'd127, 8'd255});
        enqueue_point({1'b0, 7'd0,   8'd255});
        enqueue_point({1'b0, 7'd64,  8'd128});
        wait_idle();

        // Counts below the minimum act as two; an unknown index is ignored.
        write_reg(REG_RADIUS, 16'd300);
        write_reg(REG_RINGS, 16'd0);
        write_reg(REG_SECTORS, 16'd1);
        write_reg(REG_UNUSED, 16'hFFFF);
        enqueue_point({1'b0, 7'd1, 8'd1});
        enqueue_point({1'b0, 7'd0, 8'd9});
        wait_idle();

        // Counts above the maximum act as the maximum.
        write_reg(REG_RINGS, 16'hFFFF);
        write_reg(REG_SECTORS, 16'hFFFF);
        enqueue_point({1'b0, 7'd127, 8'd255});
        enqueue_point({1'b0, 7'd5,   8'd1});
        wait_idle();

        // Random phases: fresh random settings now and then, every idling
        // pattern in turn, small grids more often than large ones.
        for (int phase = 0; phase < 16; phase++)
        begin
            set_pressure(phase);
            if (phase % 2 == 0)
            begin
                write_reg(REG_RADIUS, 16'($urandom));
                if ($urandom_range(3) == 0)
                begin
                    write_reg(REG_RINGS, 16'($urandom_range(300)));
                    write_reg(REG_SECTORS, 16'($urandom_range(150)));
                end
                else
                begin
                    write_reg(REG_RINGS, 16'($urandom_range(2, 24)));
                    write_reg(REG_SECTORS, 16'($urandom_range(2, 24)));
                end
            end
            queue_random_points(105);
            wait_idle();
        end

        if (mismatch_count == 0 && orphan_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/uvs_pkg.sv
rtl/core/uv_sphere_vertex_generator.sv
verif/uv_sphere_vertex_generator_tb.sv
